// ----- hw/rtl/ira_pkg.sv -----
// interval room allocator package: shared widths and capacity constant
// used by all modules of the room allocator, no dependencies
package ira_pkg;
  localparam int MaxRequests = 32;
  localparam int TimeW = 30;
  localparam int RoomW = 6;
endpackage

// ----- hw/rtl/ira_core_seq.sv -----
// sequencer and shared compare unit of the room allocator
// depends on ira_pkg; holds request store, order list, heap and room table
module ira_core_seq #(
  parameter int MAX_REQUESTS = ira_pkg::MaxRequests
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ira_pkg::TimeW-1:0] in_arrival,
  input  logic [ira_pkg::TimeW-1:0] in_departure,
  input  logic                     in_final_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_kind,
  output logic [ira_pkg::RoomW-1:0] out_room,
  output logic                     out_overflowed,
  output logic                     out_run_end
);
  localparam int IW = $clog2(MAX_REQUESTS);
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int TW = ira_pkg::TimeW;
  localparam int RW = ira_pkg::RoomW;

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_RD, S_SORT_CMP, S_ALLOC_RD, S_SCAN, S_PLACE, S_OUT_CNT, S_OUT_RD
  } state_t;

  state_t state_r;
  logic [TW-1:0] arr_mem [MAX_REQUESTS];
  logic [TW-1:0] dep_mem [MAX_REQUESTS];
  logic [IW-1:0] ord_mem [MAX_REQUESTS];
  logic [TW-1:0] hdep_mem [MAX_REQUESTS];
  logic [RW-1:0] hroom_mem [MAX_REQUESTS];
  logic [RW-1:0] room_mem [MAX_REQUESTS];

  logic [CW-1:0] count_r, heap_size_r, i_r, j_r;
  logic          ovf_r;
  logic [IW-1:0] v_r, cur_r, best_r, bo_r;
  logic [TW-1:0] va_r, vd_r, ba_r, bd_r, bdep_r, hd_r;
  logic [RW-1:0] broom_r, hr_r;
  logic          out_valid_r, out_kind_r, out_end_r;
  logic [RW-1:0] out_room_r;

  // shared compare unit: (a,d,idx) strictly ahead of (b,e,idx)
  logic v_first;
  always_comb begin
    v_first = (va_r != ba_r) ? (va_r < ba_r) :
              (vd_r != bd_r) ? (vd_r < bd_r) : (v_r < bo_r);
  end

  assign in_stall       = (state_r != S_LOAD);
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_room       = out_room_r;
  assign out_overflowed = ovf_r;
  assign out_run_end    = out_end_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      heap_size_r <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (count_r < CW'(MAX_REQUESTS)) begin
              arr_mem[count_r[IW-1:0]] <= in_arrival;
              dep_mem[count_r[IW-1:0]] <= in_departure;
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_final_item) begin
              i_r     <= '0;
              state_r <= S_SORT_RD;
            end
          end
        end
        // insertion sort, one compare per cycle
        S_SORT_RD: begin
          if (i_r == count_r) begin
            i_r <= '0;
            heap_size_r <= '0;
            state_r <= S_ALLOC_RD;
          end else begin
            v_r  <= i_r[IW-1:0];
            va_r <= arr_mem[i_r[IW-1:0]];
            vd_r <= dep_mem[i_r[IW-1:0]];
            j_r  <= i_r;
            if (i_r != '0) begin
              ba_r <= arr_mem[ord_mem[i_r[IW-1:0] - 1'b1]];
              bd_r <= dep_mem[ord_mem[i_r[IW-1:0] - 1'b1]];
              bo_r <= ord_mem[i_r[IW-1:0] - 1'b1];
            end
            state_r <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (j_r != '0 && v_first) begin
            ord_mem[j_r[IW-1:0]] <= ord_mem[j_r[IW-1:0] - 1'b1];
            j_r <= j_r - 1'b1;
            if (j_r > CW'(1)) begin
              ba_r <= arr_mem[ord_mem[j_r[IW-1:0] - 2'd2]];
              bd_r <= dep_mem[ord_mem[j_r[IW-1:0] - 2'd2]];
              bo_r <= ord_mem[j_r[IW-1:0] - 2'd2];
            end
          end else begin
            ord_mem[j_r[IW-1:0]] <= v_r;
            i_r     <= i_r + 1'b1;
            state_r <= S_SORT_RD;
          end
        end
        // allocation: linear min search over open rooms
        S_ALLOC_RD: begin
          if (i_r == count_r) begin
            state_r <= S_OUT_CNT;
          end else begin
            cur_r  <= ord_mem[i_r[IW-1:0]];
            best_r <= '0;
            bdep_r <= hdep_mem[0];
            broom_r <= hroom_mem[0];
            hd_r   <= hdep_mem[IW'(1)];
            hr_r   <= hroom_mem[IW'(1)];
            j_r    <= CW'(1);
            state_r <= (heap_size_r == '0) ? S_PLACE : S_SCAN;
          end
        end
        // hd_r and hr_r hold entry j, the next entry is fetched alongside
        S_SCAN: begin
          if (j_r >= heap_size_r) begin
            state_r <= S_PLACE;
          end else begin
            if (hd_r < bdep_r || (hd_r == bdep_r && hr_r < broom_r)) begin
              best_r <= j_r[IW-1:0];
              bdep_r <= hd_r;
              broom_r <= hr_r;
            end
            hd_r <= hdep_mem[j_r[IW-1:0] + 1'b1];
            hr_r <= hroom_mem[j_r[IW-1:0] + 1'b1];
            j_r <= j_r + 1'b1;
          end
        end
        S_PLACE: begin
          if (heap_size_r != '0 && arr_mem[cur_r] > bdep_r) begin
            hdep_mem[best_r] <= dep_mem[cur_r];
            room_mem[cur_r]  <= broom_r;
          end else begin
            hdep_mem[heap_size_r[IW-1:0]]  <= dep_mem[cur_r];
            hroom_mem[heap_size_r[IW-1:0]] <= RW'(heap_size_r + 1'b1);
            room_mem[cur_r] <= RW'(heap_size_r + 1'b1);
            heap_size_r <= heap_size_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
          state_r <= S_ALLOC_RD;
        end
        // result emission
        S_OUT_CNT: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= 1'b0;
          out_room_r  <= RW'(heap_size_r);
          out_end_r   <= (count_r == '0);
          i_r <= '0;
          state_r <= S_OUT_RD;
        end
        S_OUT_RD: begin
          if (!out_stall) begin
            if (out_end_r) begin
              out_valid_r <= 1'b0;
              count_r <= '0;
              heap_size_r <= '0;
              ovf_r <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              out_kind_r <= 1'b1;
              out_room_r <= room_mem[i_r[IW-1:0]];
              out_end_r  <= (i_r + 1'b1 == count_r);
              i_r <= i_r + 1'b1;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // checks
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REQUESTS)) else $error("request count beyond capacity");
  a_heap_cap: assert property (@(posedge clk) disable iff (!rst_n)
    heap_size_r <= count_r) else $error("more rooms than requests");
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT_RD) else $error("result outside emission");
endmodule

// ----- hw/rtl/interval_room_allocator_core.sv -----
// interval room allocator: after the final item the stored items are insertion-sorted, then each
// takes the open room that frees earliest if its arrival is later, else opens a new room; for n
// stored items n + 1 results follow (room count first), one per cycle unstalled
// throughput: one run at a time, one item per cycle while loading, stalled meanwhile
// synchronous active-low reset clears counts and overflow flag; stores are not cleared
// depends on ira_pkg and ira_core_seq
module interval_room_allocator_core #(
  parameter int MAX_REQUESTS = ira_pkg::MaxRequests
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ira_pkg::TimeW-1:0] in_arrival,
  input  logic [ira_pkg::TimeW-1:0] in_departure,
  input  logic                      in_final_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_kind,
  output logic [ira_pkg::RoomW-1:0] out_room,
  output logic                      out_overflowed,
  output logic                      out_run_end
);
  // sequencer with shared compare unit
  ira_core_seq #(.MAX_REQUESTS(MAX_REQUESTS)) u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_arrival, .in_departure, .in_final_item,
    .out_valid, .out_stall, .out_kind, .out_room, .out_overflowed, .out_run_end
  );
endmodule
